[rtl/pidip_pkg.sv]
// Shared types and constants for the incremental and positional PID controller.
package pidip_pkg;

    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 16;
    localparam int ERROR_W  = SAMPLE_W + 1;
    localparam int TERM_P_W = ERROR_W + 1;
    localparam int TERM_D_W = ERROR_W + 2;
    localparam int PROD_W   = GAIN_W + TERM_D_W;
    localparam int SUM_W    = PROD_W + 2;
    localparam int DRIVE_W  = 32;
    localparam int CFG_INDEX_W = 8;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t REG_GAIN_P    = 8'd0;
    localparam cfg_index_t REG_GAIN_I    = 8'd1;
    localparam cfg_index_t REG_GAIN_D    = 8'd2;
    localparam cfg_index_t REG_LOOP_MODE = 8'd3;

    localparam logic MODE_INCREMENTAL = 1'b0;
    localparam logic MODE_POSITIONAL  = 1'b1;

    // Controller configuration as held in the register file.
    typedef struct packed {
        logic [GAIN_W-1:0] gain_p;
        logic [GAIN_W-1:0] gain_i;
        logic [GAIN_W-1:0] gain_d;
        logic              loop_mode;
    } gains_t;

    // Error terms that multiply the three gains; all two's complement.
    typedef struct packed {
        logic [TERM_P_W-1:0] term_p;
        logic [ERROR_W-1:0]  term_i;
        logic [TERM_D_W-1:0] term_d;
    } terms_t;

endpackage

[rtl/pidip_terms.sv]
// First pipeline stage: error, error history, leaky integral and gain terms.
module pidip_terms
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [pidip_pkg::SAMPLE_W-1:0]     setpoint,
    input  logic [pidip_pkg::SAMPLE_W-1:0]     measurement,
    input  logic                               loop_mode,
    input  logic                               next_free,
    output logic                               terms_valid,
    output pidip_pkg::terms_t                  terms
);
    import pidip_pkg::*;

    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic               s1_free;
    logic               accept;
    terms_t             terms_reg;
    terms_t             terms_next;
    logic [ERROR_W-1:0] last_error_reg;
    logic [ERROR_W-1:0] older_reg;
    logic [ERROR_W-1:0] older_next;
    logic [ERROR_W-1:0] err;
    logic [ERROR_W:0]   leak_sum;
    logic [ERROR_W-1:0] integ;

    assign s1_free  = !s1_valid_reg || next_free;
    assign accept   = in_valid && s1_free;
    assign in_stall = !s1_free;

    always_comb
    begin
        err = {setpoint[SAMPLE_W-1], setpoint} - {measurement[SAMPLE_W-1], measurement};
        // Floor of half the sum: drop the low bit of the one-bit-wider sum.
        leak_sum = {err[ERROR_W-1], err} + {older_reg[ERROR_W-1], older_reg};
        integ    = leak_sum[ERROR_W:1];
        if (loop_mode == MODE_POSITIONAL)
        begin
            terms_next.term_p = {err[ERROR_W-1], err};
            terms_next.term_i = integ;
            terms_next.term_d = {{2{err[ERROR_W-1]}}, err}
                              - {{2{last_error_reg[ERROR_W-1]}}, last_error_reg};
            older_next        = integ;
        end
        else
        begin
            terms_next.term_p = {err[ERROR_W-1], err}
                              - {last_error_reg[ERROR_W-1], last_error_reg};
            terms_next.term_i = err;
            terms_next.term_d = {{2{err[ERROR_W-1]}}, err}
                              - {last_error_reg[ERROR_W-1], last_error_reg, 1'b0}
                              + {{2{older_reg[ERROR_W-1]}}, older_reg};
            older_next        = last_error_reg;
        end
    end

    always_comb
    begin
        if (accept)
            s1_valid_next = 1'b1;
        else if (next_free)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            last_error_reg <= '0;
            older_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (accept)
            begin
                last_error_reg <= err;
                older_reg      <= older_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            terms_reg <= terms_next;
    end

    assign terms_valid = s1_valid_reg;
    assign terms       = terms_reg;

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted transaction did not reach the term register");

    a_history_shift: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> last_error_reg == $past(err))
        else $error("last error not updated on accept");

    a_hold_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !next_free |=> s1_valid_reg && $stable(terms_reg))
        else $error("stalled term register lost or changed its contents");

endmodule

[rtl/pidip_mac.sv]
// Product and sum stages: three gain products, exact sum and 32-bit saturation.
module pidip_mac
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            terms_valid,
    input  pidip_pkg::terms_t               terms,
    input  pidip_pkg::gains_t               gains,
    output logic                            next_free,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [pidip_pkg::DRIVE_W-1:0]   drive
);
    import pidip_pkg::*;

    logic              s2_valid_reg;
    logic              s2_valid_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              s2_load;
    logic              s3_load;
    logic [PROD_W-1:0] prod_p_reg;
    logic [PROD_W-1:0] prod_i_reg;
    logic [PROD_W-1:0] prod_d_reg;
    logic [PROD_W-1:0] prod_p;
    logic [PROD_W-1:0] prod_i;
    logic [PROD_W-1:0] prod_d;
    logic [SUM_W-1:0]  sum;
    logic [DRIVE_W-1:0] sat;
    logic [DRIVE_W-1:0] drive_reg;

    assign s3_load   = s2_valid_reg && (!out_valid_reg || !out_stall);
    assign next_free = !s2_valid_reg || s3_load;
    assign s2_load   = terms_valid && next_free;

    always_comb
    begin
        prod_p = PROD_W'($signed(gains.gain_p) * $signed(terms.term_p));
        prod_i = PROD_W'($signed(gains.gain_i) * $signed(terms.term_i));
        prod_d = PROD_W'($signed(gains.gain_d) * $signed(terms.term_d));
    end

    always_comb
    begin
        sum = {{2{prod_p_reg[PROD_W-1]}}, prod_p_reg}
            + {{2{prod_i_reg[PROD_W-1]}}, prod_i_reg}
            + {{2{prod_d_reg[PROD_W-1]}}, prod_d_reg};
        // The sum fits when every bit above the 32-bit sign agrees with it.
        if (sum[SUM_W-1:DRIVE_W-1] == {(SUM_W-DRIVE_W+1){1'b0}} ||
            sum[SUM_W-1:DRIVE_W-1] == {(SUM_W-DRIVE_W+1){1'b1}})
            sat = sum[DRIVE_W-1:0];
        else if (sum[SUM_W-1])
            sat = {1'b1, {(DRIVE_W-1){1'b0}}};
        else
            sat = {1'b0, {(DRIVE_W-1){1'b1}}};
    end

    always_comb
    begin
        if (s2_load)
            s2_valid_next = 1'b1;
        else if (s3_load)
            s2_valid_next = 1'b0;
        else
            s2_valid_next = s2_valid_reg;

        if (s3_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            prod_p_reg <= prod_p;
            prod_i_reg <= prod_i;
            prod_d_reg <= prod_d;
        end
        if (s3_load)
            drive_reg <= sat;
    end

    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;

    a_products_fill: assert property (@(posedge clk) disable iff (!rst_n)
        s2_load |=> s2_valid_reg)
        else $error("product register not marked valid after load");

    a_products_held: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !s3_load |=> s2_valid_reg && $stable(prod_p_reg))
        else $error("product register dropped a transaction while blocked");

    a_result_fills: assert property (@(posedge clk) disable iff (!rst_n)
        s3_load |=> out_valid_reg && drive_reg == $past(sat))
        else $error("result register not loaded with the saturated sum");

endmodule

[rtl/pid_incremental_positional.sv]
// Top level of the incremental and positional PID controller.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------------
//  input    | in_valid / in_stall   | setpoint, measurement (Q8.8 signed)
//  output   | out_valid / out_stall | drive (Q16.16 signed, saturated)
//  config   | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One transaction is accepted per cycle while in_stall is low. The term,
// product and sum registers load in that order, and drive is valid once
// the sum register holds the saturated result.
// The error history and leaky integral update at acceptance, so consecutive
// samples follow each other with no gap. Reset clears gains, mode and history.
// Output stall backs up through each stage; in_stall rises only when the
// term register is full and cannot move on. Configuration is always ready.
module pid_incremental_positional
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [pidip_pkg::SAMPLE_W-1:0]      setpoint,
    input  logic [pidip_pkg::SAMPLE_W-1:0]      measurement,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [pidip_pkg::DRIVE_W-1:0]       drive,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  pidip_pkg::cfg_index_t               cfg_index,
    input  logic [pidip_pkg::GAIN_W-1:0]        cfg_data
);
    import pidip_pkg::*;

    gains_t gains_reg;
    gains_t gains_next;
    terms_t terms;
    logic   terms_valid;
    logic   next_free;

    // Register file: gains and mode. Unknown indexes are accepted and ignored.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        gains_next = gains_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_GAIN_P:    gains_next.gain_p    = cfg_data;
                REG_GAIN_I:    gains_next.gain_i    = cfg_data;
                REG_GAIN_D:    gains_next.gain_d    = cfg_data;
                REG_LOOP_MODE: gains_next.loop_mode = cfg_data[0];
                default:       gains_next           = gains_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gains_reg <= '0;
        else
            gains_reg <= gains_next;
    end

    // Stage one: error terms and controller state.
    pidip_terms u_terms
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .setpoint    (setpoint),
        .measurement (measurement),
        .loop_mode   (gains_reg.loop_mode),
        .next_free   (next_free),
        .terms_valid (terms_valid),
        .terms       (terms)
    );

    // Stages two and three: gain products, then exact sum with saturation.
    pidip_mac u_mac
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .terms_valid (terms_valid),
        .terms       (terms),
        .gains       (gains_reg),
        .next_free   (next_free),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .drive       (drive)
    );

endmodule
